// ===== sv/bpe_pkg.sv =====
// Shared types and codes of the breakpoint envelope generator.
package bpe_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_SAMPLE  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		POS_PERCENT  = 2'd0,
		POS_ABSOLUTE = 2'd1,
		POS_RELATIVE = 2'd2
	} pos_t;

	typedef enum logic [0:0] {
		REG_DURATION    = 1'b0,
		REG_POINT_COUNT = 1'b1
	} reg_idx_t;

	localparam logic [31:0] DURATION_RESET = 32'd48000;
	localparam logic [4:0]  COUNT_RESET    = 5'd1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  point_index;
		logic [1:0]  position_type;
		logic [31:0] point_position;
		logic [15:0] point_level;
		logic [31:0] sample_position;
	} cmd_item_t;

	typedef struct packed {
		logic [15:0] level;
		logic [4:0]  segment;
	} res_item_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic over;
	} div_stat_t;

endpackage

// ===== sv/breakpoint_envelope_generator_unit.sv =====
// Breakpoint envelope generator: sequencer, shared multiplier and serial divider.
//
// Channels: cmd_valid/cmd_stall/cmd_item carries load, restart and sample beats;
// res_valid/res_stall/res_item returns one beat per sample (level, segment).
// cfg_we/cfg_index/cfg_data writes envelope_duration (0) and point_count (1).
// One item is worked at a time; cmd_stall is high from acceptance until the
// item's work is done.
// Load: multiply for percentage positions, then store write.
// Restart: read of breakpoint 0.
// Sample: the breakpoint store's single read port sets the cost of each
// breakpoint passed and the one-bit-per-cycle divider sets the interpolation
// cost. A zero slope or an empty segment skips the divide.
// The result sits in an output register; the next item is taken as soon as
// that register is loaded. A stalled receiver holds a finished sample in its
// last state until the output register frees up.
// Reset: first segment, registers to defaults; breakpoint contents undefined
// until loaded, no clearing pass.
module breakpoint_envelope_generator_unit #(
	parameter int MAX_POINTS = 16,
	parameter int LEVEL_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  bpe_pkg::cmd_item_t  cmd_item,
	output logic                res_valid,
	input  logic                res_stall,
	output bpe_pkg::res_item_t  res_item,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int L   = LEVEL_BITS;
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int NW  = $clog2(MAX_POINTS + 1);
	localparam int CW  = (NW > 5) ? NW : 5;
	localparam int EW  = L + 32;
	localparam int SHL = (L >= 16) ? (L - 16) : 0;
	localparam int SHR = (L < 16) ? (16 - L) : 0;
	localparam logic [L-1:0] FULL = {L{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_MUL,
		ST_LD_WR,
		ST_RS_RD,
		ST_RS_USE,
		ST_SM_CLAMP,
		ST_SM_CL_USE,
		ST_SM_RD,
		ST_SM_CMP,
		ST_SM_PRV,
		ST_SM_PRV_USE,
		ST_SM_CALC,
		ST_SM_CHK,
		ST_SM_DIV_GO,
		ST_SM_DIV_WAIT,
		ST_SM_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] duration_q;
	logic [4:0]  point_count_q;

	// envelope state
	logic [NW-1:0]     next_q;
	logic [L-1:0]      start_level_q;
	logic signed [L:0] delta_q;
	logic [31:0]       last_loaded_q;
	logic              pend_q;
	logic              res_valid_q;
	bpe_pkg::res_item_t res_q;

	// datapath
	bpe_pkg::cmd_item_t item_q;
	logic [63:0]  mul_q;
	logic [31:0]  end_q;
	logic [31:0]  start_pos_q;
	logic [31:0]  range_q;
	logic         range_ok_q;
	logic [31:0]  rel_mag_q;
	logic         neg_q;
	logic [L-1:0] delta_mag_q;
	logic [L-1:0] lvl_q;

	logic [CW-1:0]  pc_ext;
	logic [NW-1:0]  n;
	logic [NW-1:0]  next_inc;
	logic [AW-1:0]  raddr;
	logic [EW-1:0]  rd_data;
	logic [31:0]    rd_pos;
	logic [L-1:0]   rd_lvl;
	logic           adv;
	logic           load_ok;
	logic           trivial;
	logic [31:0]    mul_a;
	logic [31:0]    mul_b;
	logic [47:0]    pct;
	logic [32:0]    rel_sum;
	logic [31:0]    ld_pos;
	logic [L+15:0]  lvl_in_ext;
	logic [L-1:0]   lvl_in;
	logic [L+7:0]   lvl_out_ext;
	logic [15:0]    lvl_out;
	logic           rel_neg;
	logic signed [L:0] delta_neg;
	logic signed [L+2:0] sum;
	logic [L-1:0]   lvl_div;
	bpe_pkg::div_stat_t div_stat;
	logic [L:0]     quo;
	logic           div_start;

	// point count 0 acts as 1, anything above the store depth as the depth
	assign pc_ext   = CW'(point_count_q);
	assign n        = (pc_ext == '0) ? NW'(1) :
	                  (pc_ext > CW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(pc_ext);
	assign next_inc = next_q + 1'b1;

	assign rd_pos = rd_data[EW-1:L];
	assign rd_lvl = rd_data[L-1:0];
	assign adv    = item_q.sample_position >= rd_pos;

	assign load_ok = (int'(cmd_item.point_index) < MAX_POINTS) &&
	                 (cmd_item.position_type == bpe_pkg::POS_PERCENT ||
	                  cmd_item.position_type == bpe_pkg::POS_ABSOLUTE ||
	                  cmd_item.position_type == bpe_pkg::POS_RELATIVE);

	always_comb begin
		unique case (state_q)
			ST_RS_RD:    raddr = '0;
			ST_SM_CLAMP: raddr = AW'(n - 1'b1);
			ST_SM_RD:    raddr = AW'(next_q);
			ST_SM_PRV:   raddr = AW'(next_q - 1'b1);
			default:     raddr = '0;
		endcase
	end

	// one multiplier: percentage scaling on loads, delta * offset on samples
	assign mul_a = (state_q == ST_LD_MUL) ? item_q.point_position : rel_mag_q;
	assign mul_b = (state_q == ST_LD_MUL) ? duration_q : 32'(delta_mag_q);

	assign pct     = mul_q[63:16];
	assign rel_sum = {1'b0, last_loaded_q} + {1'b0, item_q.point_position};

	always_comb begin
		unique case (item_q.position_type)
			bpe_pkg::POS_PERCENT:  ld_pos = (|pct[47:32]) ? '1 : pct[31:0];
			bpe_pkg::POS_RELATIVE: ld_pos = rel_sum[32] ? '1 : rel_sum[31:0];
			default:               ld_pos = item_q.point_position;
		endcase
	end

	assign lvl_in_ext  = ((L + 16)'(item_q.point_level) << SHL) >> SHR;
	assign lvl_in      = lvl_in_ext[L-1:0];
	assign lvl_out_ext = ((L + 8)'(lvl_q) >> SHL) << SHR;
	assign lvl_out     = lvl_out_ext[15:0];

	assign rel_neg   = item_q.sample_position < start_pos_q;
	assign delta_neg = -delta_q;
	assign trivial   = (delta_q == '0) || !range_ok_q;

	assign sum = $signed({3'b000, start_level_q}) +
	             (neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo}));

	always_comb begin
		if (div_stat.over) begin
			lvl_div = neg_q ? '0 : FULL;
		end else if (sum < 0) begin
			lvl_div = '0;
		end else if (sum > $signed({3'b000, FULL})) begin
			lvl_div = FULL;
		end else begin
			lvl_div = sum[L-1:0];
		end
	end

	assign div_start = (state_q == ST_SM_DIV_GO);

	bpe_mem #(
		.DEPTH(MAX_POINTS),
		.WIDTH(EW)
	) u_mem (
		.clk   (clk),
		.we    (state_q == ST_LD_WR),
		.waddr (AW'(item_q.point_index)),
		.wdata ({ld_pos, lvl_in}),
		.raddr (raddr),
		.rdata (rd_data)
	);

	bpe_div #(
		.LEVEL_BITS(LEVEL_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_q[EW-1:0]),
		.divisor  (range_q),
		.stat     (div_stat),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q    <= bpe_pkg::DURATION_RESET;
			point_count_q <= bpe_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpe_pkg::REG_DURATION:    duration_q    <= cfg_data;
				bpe_pkg::REG_POINT_COUNT: point_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			next_q        <= '0;
			start_level_q <= '0;
			delta_q       <= '0;
			last_loaded_q <= '0;
			pend_q        <= 1'b0;
			res_valid_q   <= 1'b0;
			res_q         <= '0;
		end else begin
			// ST_SM_OUT handles the output register itself
			if (res_valid_q && !res_stall && state_q != ST_SM_OUT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd_item.cmd)
							bpe_pkg::CMD_LOAD:    state_q <= load_ok ? ST_LD_MUL : ST_IDLE;
							bpe_pkg::CMD_RESTART: state_q <= ST_RS_RD;
							bpe_pkg::CMD_SAMPLE:  state_q <= ST_SM_CLAMP;
							default:              state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LD_MUL: state_q <= ST_LD_WR;
				ST_LD_WR: begin
					last_loaded_q <= ld_pos;
					state_q       <= ST_IDLE;
				end
				ST_RS_RD: state_q <= ST_RS_USE;
				ST_RS_USE: begin
					next_q        <= '0;
					start_level_q <= '0;
					delta_q       <= $signed({1'b0, rd_lvl});
					state_q       <= ST_IDLE;
				end
				ST_SM_CLAMP: begin
					pend_q <= 1'b0;
					// count lowered under the current segment: jump to the final decay
					if (next_q > n) begin
						next_q  <= n;
						state_q <= ST_SM_CL_USE;
					end else begin
						state_q <= ST_SM_RD;
					end
				end
				ST_SM_CL_USE: begin
					start_level_q <= rd_lvl;
					delta_q       <= -$signed({1'b0, rd_lvl});
					state_q       <= ST_SM_RD;
				end
				ST_SM_RD: state_q <= (next_q < n) ? ST_SM_CMP : ST_SM_PRV;
				ST_SM_CMP: begin
					if (adv) begin
						start_level_q <= rd_lvl;
						next_q        <= next_inc;
						if (next_inc < n) begin
							pend_q  <= 1'b1;
							state_q <= ST_SM_RD;
						end else begin
							delta_q <= -$signed({1'b0, rd_lvl});
							state_q <= ST_SM_PRV;
						end
					end else begin
						// entry just read is the new segment's end point
						if (pend_q) begin
							delta_q <= $signed({1'b0, rd_lvl}) - $signed({1'b0, start_level_q});
						end
						pend_q  <= 1'b0;
						state_q <= ST_SM_PRV;
					end
				end
				ST_SM_PRV:      state_q <= (next_q != '0) ? ST_SM_PRV_USE : ST_SM_CALC;
				ST_SM_PRV_USE:  state_q <= ST_SM_CALC;
				ST_SM_CALC:     state_q <= ST_SM_CHK;
				ST_SM_CHK:      state_q <= trivial ? ST_SM_OUT : ST_SM_DIV_GO;
				ST_SM_DIV_GO:   state_q <= ST_SM_DIV_WAIT;
				ST_SM_DIV_WAIT: state_q <= div_stat.done ? ST_SM_OUT : ST_SM_DIV_WAIT;
				ST_SM_OUT: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						res_q       <= '{level: lvl_out, segment: 5'(next_q)};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			item_q <= cmd_item;
		end
		mul_q <= {32'b0, mul_a} * {32'b0, mul_b};
		unique case (state_q)
			ST_SM_RD: begin
				if (!(next_q < n)) begin
					end_q <= duration_q;
				end
			end
			ST_SM_CMP: begin
				if (!adv) begin
					end_q <= rd_pos;
				end else if (!(next_inc < n)) begin
					end_q <= duration_q;
				end
			end
			ST_SM_PRV: begin
				if (next_q == '0) begin
					start_pos_q <= '0;
				end
			end
			ST_SM_PRV_USE: start_pos_q <= rd_pos;
			ST_SM_CALC: begin
				range_ok_q  <= end_q > start_pos_q;
				range_q     <= end_q - start_pos_q;
				rel_mag_q   <= rel_neg ? (start_pos_q - item_q.sample_position)
				                       : (item_q.sample_position - start_pos_q);
				neg_q       <= delta_q[L] ^ rel_neg;
				delta_mag_q <= delta_q[L] ? delta_neg[L-1:0] : delta_q[L-1:0];
			end
			ST_SM_CHK: begin
				if (trivial) begin
					lvl_q <= start_level_q;
				end
			end
			ST_SM_DIV_WAIT: begin
				if (div_stat.done) begin
					lvl_q <= lvl_div;
				end
			end
			default: ;
		endcase
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	a_next_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= NW'(MAX_POINTS))
		else $error("next breakpoint beyond store depth");

	a_segment_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SM_PRV) |-> (next_q <= n))
		else $error("segment index past active point count");

	a_div_free_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SM_DIV_GO) |-> !div_stat.busy)
		else $error("divider started while busy");

	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SM_OUT && res_valid_q && res_stall) |=> (state_q == ST_SM_OUT))
		else $error("sample result dropped while output stalled");

endmodule

// ===== sv/bpe_mem.sv =====
// Breakpoint store: one write port, one registered read port.
module bpe_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/bpe_div.sv =====
// Serial restoring divider, one quotient bit per cycle, with early overflow detect.
module bpe_div #(
	parameter int LEVEL_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [LEVEL_BITS+31:0]  dividend,
	input  logic [31:0]             divisor,
	output bpe_pkg::div_stat_t      stat,
	output logic [LEVEL_BITS:0]     quotient
);

	localparam int QW   = LEVEL_BITS + 1;
	localparam int PW   = LEVEL_BITS + 32;
	localparam int CNTW = $clog2(QW + 1);

	logic            busy_q;
	logic            done_q;
	logic            over_q;
	logic [CNTW-1:0] cnt_q;
	logic [31:0]     rem_q;
	logic [QW-1:0]   low_q;

	logic [31:0] hi;
	logic        hi_over;
	logic [32:0] trial;
	logic        ge;

	// quotient wider than QW bits saturates the level anyway
	assign hi      = 32'(dividend[PW-1:QW]);
	assign hi_over = hi >= divisor;
	assign trial   = {rem_q, low_q[QW-1]};
	assign ge      = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !hi_over;
				done_q <= hi_over;
				cnt_q  <= CNTW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			over_q <= hi_over;
			rem_q  <= hi;
			low_q  <= dividend[QW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, divisor}) : trial[31:0];
			low_q <= {low_q[QW-2:0], ge};
		end
	end

	assign stat     = '{busy: busy_q, done: done_q, over: over_q};
	assign quotient = low_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == CNTW'(1)) |=> done_q)
		else $error("divider missed its done pulse");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !over_q) |-> (rem_q < divisor))
		else $error("divider remainder not reduced");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the breakpoint envelope generator: directed script, then random phases.
module tb_top;

	localparam logic [1:0]  CMD_UNUSED    = 2'd3;
	localparam logic [1:0]  POS_UNUSED    = 2'd3;
	localparam int unsigned MAX_SLOTS     = 16;
	localparam int          SETTLE_CYCLES = 80;
	localparam int          QUIET_LIMIT   = 4000;
	localparam int          PHASES        = 12;
	localparam int          PHASE_BEATS   = 65;

	typedef struct packed {
		bit                  is_cfg;
		bpe_pkg::reg_idx_t   reg_sel;
		logic [31:0]         reg_val;
		bpe_pkg::cmd_item_t  beat;
		bit                  typed;
		bpe_pkg::res_item_t  want;
	} step_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	bpe_pkg::cmd_item_t cmd_item = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	bpe_pkg::res_item_t res_item;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_index = bpe_pkg::REG_DURATION;
	logic [31:0] cfg_data = '0;

	// envelope state as the bench tracks it
	logic [31:0]        bp_pos [MAX_SLOTS];
	logic [15:0]        bp_lvl [MAX_SLOTS];
	logic [15:0]        loaded = '0;
	logic [31:0]        last_pos = '0;
	logic [4:0]         next_bp = '0;
	logic [15:0]        seg_start = '0;
	logic signed [16:0] seg_delta = '0;
	logic [31:0]        dur_reg = bpe_pkg::DURATION_RESET;
	logic [4:0]         count_reg = bpe_pkg::COUNT_RESET;

	bpe_pkg::res_item_t pending_levels[$];
	bpe_pkg::res_item_t level_head;
	step_t     script[$];
	int        fail_count = 0;
	int        beat_count = 0;
	int        quiet_cycles = 0;
	bit        calm = 1'b0;

	breakpoint_envelope_generator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned active_points(input logic [4:0] c);
		if (c == 5'd0) return 1;
		if (c > 5'd16) return MAX_SLOTS;
		return int'(c);
	endfunction

	// next_bp has just moved; reload the segment registers
	function automatic void open_segment(input int unsigned n);
		seg_start = bp_lvl[next_bp - 5'd1];
		if (next_bp < n) seg_delta = $signed({1'b0, bp_lvl[next_bp]}) - $signed({1'b0, seg_start});
		else seg_delta = -$signed({1'b0, seg_start});
	endfunction

	function automatic void track_envelope(input bpe_pkg::cmd_item_t b, output bit has_res,
			output bpe_pkg::res_item_t r);
		logic [63:0]  p64;
		int unsigned  n;
		longint       start_pos, end_pos, span, lvl;
		has_res = 1'b0;
		r = '0;
		case (b.cmd)
		bpe_pkg::CMD_LOAD: begin
			if (b.position_type != POS_UNUSED) begin
				case (b.position_type)
				bpe_pkg::POS_PERCENT:
					p64 = ({32'd0, b.point_position} * {32'd0, dur_reg}) >> 16;
				bpe_pkg::POS_ABSOLUTE: p64 = {32'd0, b.point_position};
				default:      p64 = {32'd0, last_pos} + {32'd0, b.point_position};
				endcase
				if (p64 > 64'hFFFF_FFFF) p64 = 64'hFFFF_FFFF;
				bp_pos[b.point_index] = p64[31:0];
				bp_lvl[b.point_index] = b.point_level;
				loaded[b.point_index] = 1'b1;
				last_pos = p64[31:0];
			end
		end
		bpe_pkg::CMD_RESTART: begin
			next_bp = 5'd0;
			seg_start = 16'd0;
			seg_delta = $signed({1'b0, bp_lvl[0]});
		end
		bpe_pkg::CMD_SAMPLE: begin
			n = active_points(count_reg);
			if (next_bp > n) begin
				next_bp = 5'(n);
				open_segment(n);
			end
			while (next_bp < n && b.sample_position >= bp_pos[next_bp]) begin
				next_bp = next_bp + 5'd1;
				open_segment(n);
			end
			if (next_bp != 5'd0) start_pos = longint'({32'd0, bp_pos[next_bp - 5'd1]});
			else start_pos = 0;
			if (next_bp < n) end_pos = longint'({32'd0, bp_pos[next_bp]});
			else end_pos = longint'({32'd0, dur_reg});
			span = end_pos - start_pos;
			if (seg_delta == 0 || span <= 0) begin
				lvl = longint'({48'd0, seg_start});
			end else begin
				lvl = longint'({48'd0, seg_start}) + (longint'(seg_delta) *
					(longint'({32'd0, b.sample_position}) - start_pos)) / span;
			end
			if (lvl < 0) lvl = 0;
			if (lvl > 65535) lvl = 65535;
			r.level = lvl[15:0];
			r.segment = next_bp;
			has_res = 1'b1;
		end
		default: ;
		endcase
	endfunction

	function automatic bpe_pkg::cmd_item_t rand_beat();
		bpe_pkg::cmd_item_t b;
		b.cmd = ($urandom_range(15) == 0) ? CMD_UNUSED : 2'($urandom_range(2));
		b.point_index = 4'($urandom_range(15));
		b.position_type = ($urandom_range(7) == 0) ? POS_UNUSED : 2'($urandom_range(2));
		b.point_position = $urandom;
		b.point_level = 16'($urandom_range(16'hFFFF));
		b.sample_position = $urandom;
		return b;
	endfunction

	// fraction of the duration (Q16.16, may exceed one) to ticks, saturated
	function automatic logic [31:0] scale_pos(input int unsigned frac);
		logic [63:0] p;
		p = ({32'd0, dur_reg} * {32'd0, frac}) >> 16;
		return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
	endfunction

	// every slot a sample or restart may read has been loaded
	function automatic bit slots_ready();
		logic [16:0] m;
		m = (17'd1 << active_points(count_reg)) - 17'd1;
		return (loaded & m[15:0]) == m[15:0];
	endfunction

	function automatic step_t load_row(input logic [3:0] idx, input logic [1:0] typ,
			input logic [31:0] pos, input logic [15:0] lvl);
		step_t s;
		s = '0;
		s.beat = rand_beat();
		s.beat.cmd = bpe_pkg::CMD_LOAD;
		s.beat.point_index = idx;
		s.beat.position_type = typ;
		s.beat.point_position = pos;
		s.beat.point_level = lvl;
		return s;
	endfunction

	function automatic step_t op_row(input logic [1:0] op, input logic [31:0] sp,
			input bit typed, input logic [15:0] lvl, input logic [4:0] seg);
		step_t s;
		s = '0;
		s.beat = rand_beat();
		s.beat.cmd = op;
		s.beat.sample_position = sp;
		s.typed = typed;
		s.want.level = lvl;
		s.want.segment = seg;
		return s;
	endfunction

	function automatic step_t cfg_row(input bpe_pkg::reg_idx_t sel, input logic [31:0] val);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.reg_sel = sel;
		s.reg_val = val;
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < 200) $display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic send_beat(input bpe_pkg::cmd_item_t beat, input bit typed,
			input bpe_pkg::res_item_t want);
		bit                 got;
		bpe_pkg::res_item_t r;
		while (!calm && $urandom_range(99) < 27) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= beat;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		track_envelope(beat, got, r);
		if (got) pending_levels.push_back(typed ? want : r);
		if (!(beat.cmd == CMD_UNUSED ||
				(beat.cmd == bpe_pkg::CMD_LOAD && beat.position_type == POS_UNUSED)))
			beat_count++;
	endtask

	// idle the command side until all results are in and the block has settled
	task automatic drain();
		cmd_valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input bit wr_dur, input logic [31:0] dur, input bit wr_cnt,
			input logic [4:0] cnt);
		drain();
		if (wr_dur) begin
			cfg_we <= 1'b1;
			cfg_index <= bpe_pkg::REG_DURATION;
			cfg_data <= dur;
			@(posedge clk);
			dur_reg = dur;
		end
		if (wr_cnt) begin
			cfg_we <= 1'b1;
			cfg_index <= bpe_pkg::REG_POINT_COUNT;
			cfg_data <= {27'd0, cnt};
			@(posedge clk);
			count_reg = cnt;
		end
		cfg_we <= 1'b0;
	endtask

	// result side: check accepted beats, stall at random
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_levels.size() == 0) begin
				report_mismatch("result beat with nothing pending");
			end else begin
				level_head = pending_levels.pop_front();
				if (res_item.level !== level_head.level)
					report_mismatch($sformatf("level %h, want %h", res_item.level,
						level_head.level));
				if (res_item.segment !== level_head.segment)
					report_mismatch($sformatf("segment %0d, want %0d", res_item.segment,
						level_head.segment));
			end
		end
		res_stall <= !calm && ($urandom_range(99) < 27);
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		bpe_pkg::cmd_item_t b;
		int unsigned n, m, frac, g, i, j, slot, pick;
		int          stop_at;
		logic [31:0] target, dur;
		logic [15:0] lvl, prev;

		// reset state: sample before any restart sees a flat zero segment
		script.push_back(load_row(4'd0, bpe_pkg::POS_ABSOLUTE, 32'd1000, 16'hFFFF));
		script.push_back(op_row(bpe_pkg::CMD_SAMPLE, 32'd0, 1'b1, 16'h0000, 5'd0));
		script.push_back(op_row(bpe_pkg::CMD_RESTART, 32'd0, 1'b0, 16'h0000, 5'd0));
		script.push_back(op_row(bpe_pkg::CMD_SAMPLE, 32'd500, 1'b1, 16'h7FFF, 5'd0));
		script.push_back(op_row(bpe_pkg::CMD_SAMPLE, 32'd1000, 1'b1, 16'hFFFF, 5'd1));
		script.push_back(op_row(bpe_pkg::CMD_SAMPLE, 32'd48000, 1'b1, 16'h0000, 5'd1));
		script.push_back(op_row(bpe_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 1'b1, 16'h0000, 5'd1));
		script.push_back(load_row(4'd1, bpe_pkg::POS_PERCENT, 32'h0000_FFFF, 16'h0000));
		script.push_back(load_row(4'd2, bpe_pkg::POS_RELATIVE, 32'hFFFF_FFFF, 16'h8000));
		script.push_back(load_row(4'd3, bpe_pkg::POS_RELATIVE, 32'd5, 16'h1234));
		script.push_back(load_row(4'd4, POS_UNUSED, 32'd77, 16'h5555));
		script.push_back(op_row(CMD_UNUSED, 32'd0, 1'b0, 16'h0000, 5'd0));
		script.push_back(cfg_row(bpe_pkg::REG_POINT_COUNT, 32'd4));
		script.push_back(op_row(bpe_pkg::CMD_SAMPLE, 32'd47999, 1'b0, 16'h0000, 5'd0));
		// two saturated points pass at once, then the decay range is empty
		script.push_back(op_row(bpe_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 1'b1, 16'h1234, 5'd4));
		// count below next_bp: falls back to the decay after point 0
		script.push_back(cfg_row(bpe_pkg::REG_POINT_COUNT, 32'd0));
		script.push_back(op_row(bpe_pkg::CMD_SAMPLE, 32'd24000, 1'b0, 16'h0000, 5'd0));
		script.push_back(op_row(bpe_pkg::CMD_SAMPLE, 32'd0, 1'b0, 16'h0000, 5'd0));
		script.push_back(load_row(4'd1, bpe_pkg::POS_ABSOLUTE, 32'd2000, 16'hFFFF));
		script.push_back(cfg_row(bpe_pkg::REG_POINT_COUNT, 32'd2));
		script.push_back(op_row(bpe_pkg::CMD_SAMPLE, 32'd1500, 1'b0, 16'h0000, 5'd0));
		script.push_back(op_row(bpe_pkg::CMD_RESTART, 32'd0, 1'b0, 16'h0000, 5'd0));
		// equal levels: flat segment
		script.push_back(op_row(bpe_pkg::CMD_SAMPLE, 32'd1000, 1'b1, 16'hFFFF, 5'd1));
		script.push_back(load_row(4'd15, bpe_pkg::POS_PERCENT, 32'd0, 16'h0000));
		script.push_back(cfg_row(bpe_pkg::REG_DURATION, 32'hFFFF_FFFF));
		script.push_back(load_row(4'd5, bpe_pkg::POS_PERCENT, 32'hFFFF_FFFF, 16'hFFFF));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			if (script[k].is_cfg)
				set_regs(script[k].reg_sel == bpe_pkg::REG_DURATION, script[k].reg_val,
					script[k].reg_sel == bpe_pkg::REG_POINT_COUNT, script[k].reg_val[4:0]);
			else
				send_beat(script[k].beat, script[k].typed, script[k].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: set_regs(1'b1, 32'hFFFF_FFFF, 1'b1, 5'd31);
			1: set_regs(1'b1, 32'd1, 1'b1, 5'd16);
			2: set_regs(1'b1, bpe_pkg::DURATION_RESET, 1'b1, 5'd1);
			default: begin
				pick = $urandom_range(3);
				if (pick == 0) dur = $urandom;
				else if (pick == 1) dur = $urandom_range(5000, 1);
				else if (pick == 2) dur = 32'hFFFF_FFFF;
				else dur = $urandom_range(200000, 1000);
				if (dur == 32'd0) dur = 32'd1;
				set_regs($urandom_range(3) != 0, dur, 1'b1, 5'($urandom_range(31)));
			end
			endcase
			calm = (ph == 5);
			stop_at = beat_count + PHASE_BEATS;
			while (beat_count < stop_at) begin
				if ($urandom_range(9) < 3) begin
					b = rand_beat();
					if ((b.cmd == bpe_pkg::CMD_RESTART || b.cmd == bpe_pkg::CMD_SAMPLE) &&
							!slots_ready()) begin
						slot = 0;
						for (i = MAX_SLOTS; i > 0; i--)
							if (!loaded[i - 1]) slot = i - 1;
						b.cmd = bpe_pkg::CMD_LOAD;
						b.point_index = 4'(slot);
						b.position_type = 2'($urandom_range(2));
					end
					send_beat(b, 1'b0, '0);
				end else begin
					// program all active points in rising order, usually restart, sweep
					n = active_points(count_reg);
					frac = 0;
					prev = 16'($urandom_range(16'hFFFF));
					for (i = 0; i < n; i++) begin
						if ($urandom_range(5) != 0) frac += $urandom_range(2 * 65536 / (n + 1));
						case ($urandom_range(7))
						0: lvl = prev;
						1: lvl = 16'h0000;
						2: lvl = 16'hFFFF;
						default: lvl = 16'($urandom_range(16'hFFFF));
						endcase
						prev = lvl;
						target = scale_pos(frac);
						b = rand_beat();
						b.cmd = bpe_pkg::CMD_LOAD;
						b.point_index = 4'(i);
						b.point_level = lvl;
						pick = $urandom_range(2);
						if (pick == 0) begin
							b.position_type = bpe_pkg::POS_PERCENT;
							b.point_position = frac;
						end else if (pick == 1 || target < last_pos) begin
							b.position_type = bpe_pkg::POS_ABSOLUTE;
							b.point_position = target;
						end else begin
							b.position_type = bpe_pkg::POS_RELATIVE;
							b.point_position = target - last_pos;
						end
						send_beat(b, 1'b0, '0);
					end
					if ($urandom_range(5) != 0) begin
						b = rand_beat();
						b.cmd = bpe_pkg::CMD_RESTART;
						send_beat(b, 1'b0, '0);
					end
					m = 2 * n + $urandom_range(6, 2);
					g = 0;
					for (j = 0; j < m; j++) begin
						b = rand_beat();
						b.cmd = bpe_pkg::CMD_SAMPLE;
						if ($urandom_range(4) == 0) begin
							b.sample_position = bp_pos[$urandom_range(n - 1)];
						end else begin
							b.sample_position = scale_pos(g);
							g += $urandom_range(2 * 70000 / m);
						end
						send_beat(b, 1'b0, '0);
					end
				end
			end
		end
		calm = 1'b0;

		drain();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
